>>> rtl/rlebd_pkg.sv
// Shared types and constants for the run-length byte decoder.
package rlebd_pkg;

   localparam int OUT_LANES  = 8;
   localparam int LANE_W     = 8;
   localparam int OUT_W      = OUT_LANES * LANE_W;
   localparam int CNT_W      = 4;
   localparam int RSP_DATA_W = ((OUT_W + CNT_W + 7) / 8) * 8;
   localparam int SIZE_W     = 24;
   localparam int REM_W      = SIZE_W + 1;
   localparam int RUN_W      = 8;

   localparam logic [7:0] LEN_MASK   = 8'h7F;
   localparam logic [7:0] REPEAT_BIT = 8'h80;

   // Controller to datapath commands.
   typedef struct packed {
      logic start;     // reload remaining count from the size register
      logic decode;    // command byte: subtract length, load run length
      logic rep_load;  // hold the repeat value
      logic rep_emit;  // load one packed beat of repeat copies
      logic lit_load;  // load one literal beat, count down the run
      logic out_last;
      logic out_done;
   } rlebd_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic total_zero;
      logic rem_le0;
      logic run_le1;
      logic run_le_lanes;
   } rlebd_stat_type;

endpackage

>>> rtl/rlebd_dpath.sv
// Datapath: size register, remaining count, run length and output beat register.
module rlebd_dpath
   import rlebd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SIZE_W-1:0]     csr_wr_data,
   input  logic [7:0]            in_byte,
   input  rlebd_cmd_type         cmd,
   output rlebd_stat_type        stat,
   output logic [OUT_W-1:0]      out_bytes,
   output logic [CNT_W-1:0]      out_count,
   output logic                  out_run_end,
   output logic                  out_frame_done
);

   logic [SIZE_W-1:0]       total_ff;
   logic signed [REM_W-1:0] rem_ff, rem_in, rem_base;
   logic [RUN_W-1:0]        run_left_ff, run_left_in;
   logic [7:0]              rep_byte_ff;
   logic [OUT_W-1:0]        out_bytes_ff, out_bytes_in;
   logic [CNT_W-1:0]        out_count_ff, out_count_in;
   logic                    out_last_ff, out_done_ff;
   logic [RUN_W-1:0]        cmd_len;
   logic [CNT_W-1:0]        emit_cnt;
   logic [OUT_W-1:0]        rep_word;

   assign cmd_len  = (in_byte & LEN_MASK) + RUN_W'(1);
   assign rem_base = cmd.start ? $signed({1'b0, total_ff}) : rem_ff;
   assign emit_cnt = stat.run_le_lanes ? run_left_ff[CNT_W-1:0] : CNT_W'(OUT_LANES);

   always_comb begin
      rep_word = '0;
      for (int i = 0; i < OUT_LANES; i++) begin
         if (CNT_W'(i) < emit_cnt) begin
            rep_word[i*LANE_W +: LANE_W] = rep_byte_ff;
         end
      end
   end

   always_comb begin
      rem_in       = rem_ff;
      run_left_in  = run_left_ff;
      out_bytes_in = out_bytes_ff;
      out_count_in = out_count_ff;
      if (cmd.decode) begin
         rem_in      = rem_base - $signed({{(REM_W-RUN_W){1'b0}}, cmd_len});
         run_left_in = cmd_len;
      end else if (cmd.start) begin
         rem_in      = rem_base;
         run_left_in = '0;
      end
      if (cmd.rep_emit) begin
         out_bytes_in = rep_word;
         out_count_in = emit_cnt;
         run_left_in  = run_left_ff - RUN_W'(emit_cnt);
      end
      if (cmd.lit_load) begin
         out_bytes_in = OUT_W'(in_byte);
         out_count_in = CNT_W'(1);
         run_left_in  = cmd.out_last ? '0 : run_left_ff - RUN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         rem_ff      <= '0;
         run_left_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         rem_ff      <= rem_in;
         run_left_ff <= run_left_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (cmd.rep_load) begin
         rep_byte_ff <= in_byte;
      end
      if (cmd.rep_emit || cmd.lit_load) begin
         out_last_ff <= cmd.out_last;
         out_done_ff <= cmd.out_done;
      end
      out_bytes_ff <= out_bytes_in;
      out_count_ff <= out_count_in;
   end

   assign stat.total_zero   = (total_ff == '0);
   assign stat.rem_le0      = rem_ff[REM_W-1] || (rem_ff == '0);
   assign stat.run_le1      = (run_left_ff <= RUN_W'(1));
   assign stat.run_le_lanes = (run_left_ff <= RUN_W'(OUT_LANES));

   assign out_bytes      = out_bytes_ff;
   assign out_count      = out_count_ff;
   assign out_run_end    = out_last_ff;
   assign out_frame_done = out_done_ff;

endmodule

>>> rtl/rlebd_ctrl.sv
// Controller: decode phase, frame tracking, repeat emission and output valid.
module rlebd_ctrl
   import rlebd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     in_byte,
   input  logic           frame_start,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  rlebd_stat_type stat,
   output rlebd_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CMD,
      ST_REP,
      ST_LIT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in, phase;
   logic      frame_over_ff, frame_over_in;
   logic      done_ff, done_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free, accept, drop;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff != ST_EMIT) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign phase      = frame_start ? ST_CMD : state_ff;
   assign drop       = frame_start ? stat.total_zero : frame_over_ff;

   always_comb begin
      state_in      = state_ff;
      frame_over_in = frame_over_ff;
      done_in       = done_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      cmd           = '0;
      if (accept) begin
         if (frame_start) begin
            cmd.start     = 1'b1;
            state_in      = ST_CMD;
            frame_over_in = stat.total_zero;
         end
         if (!drop) begin
            unique case (phase)
               ST_REP: begin
                  done_in  = stat.rem_le0;
                  cmd.rep_load = 1'b1;
                  state_in = ST_EMIT;
               end
               ST_LIT: begin
                  cmd.lit_load = 1'b1;
                  cmd.out_last = stat.run_le1;
                  cmd.out_done = stat.run_le1 && stat.rem_le0;
                  out_valid_in = 1'b1;
                  if (stat.run_le1) begin
                     state_in = ST_CMD;
                     if (stat.rem_le0) begin
                        frame_over_in = 1'b1;
                     end
                  end
               end
               default: begin
                  cmd.decode = 1'b1;
                  state_in   = ((in_byte & REPEAT_BIT) != '0) ? ST_REP : ST_LIT;
               end
            endcase
         end
      end else if (state_ff == ST_EMIT && out_free) begin
         // One packed beat per cycle while the output register is free, until the run is spent.
         cmd.rep_emit = 1'b1;
         cmd.out_last = stat.run_le_lanes;
         cmd.out_done = stat.run_le_lanes && done_ff;
         out_valid_in = 1'b1;
         if (stat.run_le_lanes) begin
            state_in      = ST_CMD;
            frame_over_in = done_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CMD;
         frame_over_ff <= 1'b1;
         done_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_over_ff <= frame_over_in;
         done_ff       <= done_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_emit_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !frame_over_ff)
      else $error("repeat emission outside an active frame");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.rep_emit || cmd.lit_load) && cmd.out_done |-> cmd.out_last)
      else $error("frame done on a beat that does not end its run");

   a_done_closes_frame: assert property (@(posedge clock) disable iff (reset)
      (cmd.rep_emit || cmd.lit_load) && cmd.out_done |=> frame_over_ff && rsp_tvalid)
      else $error("frame still open after its final beat");

   a_emit_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.rep_emit |-> !accept && !cmd.decode)
      else $error("input taken while a repeat run is emitted");

endmodule

>>> rtl/rle_byte_decoder.sv
// Top level of the run-length byte decoder.
//
//  channel   dir  handshake              payload
//  req       in   req_tvalid/req_tready  tdata = in_byte, tuser = frame_start
//  rsp       out  rsp_tvalid/rsp_tready  tdata = out_bytes, out_count; tlast, tuser
//  csr       in   csr_wr_en              csr_wr_data = total_bytes
//
// Command, literal and dropped bytes each take a single input transfer. A repeat-value byte is
// followed by ceil(n / 8) output beats, one per cycle while not stalled, from the emit loop.
// Reset is synchronous; no frame is active after it until a frame start.
// A full output register that is not taken stalls input and emission alike.
module rle_byte_decoder
   import rlebd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] in_byte
   input  logic                  req_tuser,   // [0] frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [63:0] out_bytes, [67:64] out_count
   output logic                  rsp_tlast,   // out_run_end
   output logic                  rsp_tuser,   // [0] out_frame_done
   input  logic                  csr_wr_en,
   input  logic [SIZE_W-1:0]     csr_wr_data
);

   rlebd_cmd_type    cmd;
   rlebd_stat_type   stat;
   logic [OUT_W-1:0] out_bytes;
   logic [CNT_W-1:0] out_count;

   rlebd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .in_byte     (req_tdata),
      .frame_start (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   rlebd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .in_byte        (req_tdata),
      .cmd            (cmd),
      .stat           (stat),
      .out_bytes      (out_bytes),
      .out_count      (out_count),
      .out_run_end    (rsp_tlast),
      .out_frame_done (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W-OUT_W-CNT_W){1'b0}}, out_count, out_bytes};

endmodule
